// ===== rtl/priority_region_memory_map_assert.svh =====
// Assertion macros for the region memory map checker.
`ifndef PRIORITY_REGION_MEMORY_MAP_ASSERT_SVH
`define PRIORITY_REGION_MEMORY_MAP_ASSERT_SVH

// Check cons in the same cycle as ante.
`define PRM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define PRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/prm_pkg.sv =====
// Shared constants, codes and types of the region memory map.
package prm_pkg;

  localparam int MAX_REGION_COUNT = 16;
  localparam int REGION_IW = (MAX_REGION_COUNT > 1) ? $clog2(MAX_REGION_COUNT) : 1;
  localparam int COUNT_W = $clog2(MAX_REGION_COUNT + 1);

  // Backing store depth is a power of two, 2^16 entries.
  localparam int BACKING_AW = 16;
  localparam int BACKING_DEPTH = 1 << BACKING_AW;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] CMD_READ     = 3'd0;
  localparam logic [2:0] CMD_WRITE    = 3'd1;
  localparam logic [2:0] CMD_MAP_ROM  = 3'd2;
  localparam logic [2:0] CMD_MAP_RAM  = 3'd3;
  localparam logic [2:0] CMD_MAP_FILL = 3'd4;
  localparam logic [2:0] CMD_LOAD     = 3'd5;

  localparam logic [1:0] KIND_ROM  = 2'd0;
  localparam logic [1:0] KIND_RAM  = 2'd1;
  localparam logic [1:0] KIND_FILL = 2'd2;

  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Classified beat handed from the front to the back.
  typedef struct packed {
    logic [1:0]            op;
    logic [BACKING_AW-1:0] index;
    logic [7:0]            wdata;
    logic [7:0]            rd;
    logic                  mapped;
    logic                  map_accepted;
  } op_t;

endpackage

// ===== rtl/prm_in_if.sv =====
// Input channel: one bus or map command per beat.
interface prm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic [15:0] region_length;
  logic [7:0]  fill_value;
  logic [15:0] region_base;

  modport source (output valid, cmd, address, write_data, region_length, fill_value,
                  region_base, input ready);
  modport sink (input valid, cmd, address, write_data, region_length, fill_value,
                region_base, output ready);
endinterface

// ===== rtl/prm_out_if.sv =====
// Output channel: one result per beat.
interface prm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       mapped;
  logic       map_accepted;

  modport source (output valid, read_data, mapped, map_accepted, input ready);
  modport sink (input valid, read_data, mapped, map_accepted, output ready);
endinterface

// ===== rtl/prm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module prm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/prm_front.sv =====
// Front end: region table, newest-first address search and command classification.
module prm_front import prm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  prm_in_if.sink     req,
  input  logic       queue_full,
  output logic       push,
  output op_t        push_op
);

  logic [15:0]        start_addr  [MAX_REGION_COUNT];
  logic [15:0]        end_addr    [MAX_REGION_COUNT];
  logic [1:0]         region_kind [MAX_REGION_COUNT];
  logic [7:0]         fill_byte   [MAX_REGION_COUNT];
  logic [15:0]        base_offset [MAX_REGION_COUNT];
  logic [COUNT_W-1:0] used_entries;
  logic [7:0]         default_fill;

  logic                 hit;
  logic [REGION_IW-1:0] hit_idx;
  logic [15:0]          offset;
  logic [15:0]          store_sum;
  logic                 table_full;
  logic                 is_map;
  logic                 do_map;
  logic [1:0]           map_kind;
  logic [15:0]          span;
  logic [15:0]          end_new;

  assign req.ready = !queue_full;
  assign push      = req.valid && !queue_full;

  // Later entries override earlier ones, so the newest hit wins.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < MAX_REGION_COUNT; i++) begin
      if (COUNT_W'(i) < used_entries && req.address >= start_addr[i] &&
          req.address <= end_addr[i]) begin
        hit     = 1'b1;
        hit_idx = REGION_IW'(i);
      end
    end
  end

  assign offset     = req.address - start_addr[hit_idx];
  assign store_sum  = base_offset[hit_idx] + offset;
  assign table_full = (used_entries == COUNT_W'(MAX_REGION_COUNT));
  assign is_map     = (req.cmd == CMD_MAP_ROM) || (req.cmd == CMD_MAP_RAM) ||
                      (req.cmd == CMD_MAP_FILL);
  assign do_map     = push && is_map && !table_full;
  assign span       = (req.region_length != 16'd0) ? (req.region_length - 16'd1) : 16'd0;
  assign end_new    = req.address + span;

  always_comb begin
    unique case (req.cmd)
      CMD_MAP_RAM:  map_kind = KIND_RAM;
      CMD_MAP_FILL: map_kind = KIND_FILL;
      default:      map_kind = KIND_ROM;
    endcase
  end

  always_comb begin
    push_op              = '0;
    push_op.wdata        = req.write_data;
    push_op.index        = store_sum[BACKING_AW-1:0];
    unique case (req.cmd)
      CMD_READ: begin
        push_op.mapped = hit;
        if (!hit) begin
          push_op.rd = default_fill;
        end else if (region_kind[hit_idx] == KIND_FILL) begin
          push_op.rd = fill_byte[hit_idx];
        end else begin
          push_op.op = OP_READ;
        end
      end
      CMD_WRITE: begin
        push_op.mapped = hit;
        if (hit && region_kind[hit_idx] == KIND_RAM) begin
          push_op.op = OP_WRITE;
        end
      end
      CMD_MAP_ROM, CMD_MAP_RAM, CMD_MAP_FILL: begin
        push_op.map_accepted = !table_full;
      end
      CMD_LOAD: begin
        push_op.op    = OP_WRITE;
        push_op.index = req.address[BACKING_AW-1:0];
      end
      default: begin
        push_op.op = OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_entries <= '0;
      default_fill <= 8'd0;
    end else begin
      if (cfg_we) begin
        default_fill <= cfg_wdata;
      end
      if (do_map) begin
        used_entries <= used_entries + COUNT_W'(1);
      end
    end
  end

  // Append at the first free entry.
  always_ff @(posedge clk) begin
    if (do_map) begin
      start_addr[used_entries[REGION_IW-1:0]]  <= req.address;
      end_addr[used_entries[REGION_IW-1:0]]    <= end_new;
      region_kind[used_entries[REGION_IW-1:0]] <= map_kind;
      fill_byte[used_entries[REGION_IW-1:0]]   <= req.fill_value;
      base_offset[used_entries[REGION_IW-1:0]] <= req.region_base;
    end
  end

endmodule

// ===== rtl/prm_queue.sv =====
// Short queue of classified beats between the front and the back.
module prm_queue import prm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  output logic head_valid,
  output op_t  head,
  input  logic pop
);

  op_t                 entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr;
  logic [QUEUE_AW-1:0] rptr;
  logic [QUEUE_CW-1:0] count;

  assign full       = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rptr <= (rptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + QUEUE_CW'(1);
      end else if (pop && !push) begin
        count <= count - QUEUE_CW'(1);
      end
    end
  end

endmodule

// ===== rtl/prm_back.sv =====
// Back end: backing store access and the result register.
module prm_back import prm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  op_t       head,
  output logic      pop,
  prm_out_if.source rsp
);

  logic       res_valid;
  logic       res_is_read;
  logic [7:0] res_rd;
  logic       res_mapped;
  logic       res_map_accepted;
  logic [7:0] store_rdata;

  // Advance only when the result slot is empty or being taken.
  assign pop = head_valid && (!res_valid || rsp.ready);

  prm_ram #(
    .WIDTH (8),
    .DEPTH (BACKING_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (pop && head.op == OP_WRITE),
    .waddr (head.index),
    .wdata (head.wdata),
    .re    (pop && head.op == OP_READ),
    .raddr (head.index),
    .rdata (store_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_is_read      <= (head.op == OP_READ);
      res_rd           <= head.rd;
      res_mapped       <= head.mapped;
      res_map_accepted <= head.map_accepted;
    end
  end

  assign rsp.valid        = res_valid;
  assign rsp.read_data    = res_is_read ? store_rdata : res_rd;
  assign rsp.mapped       = res_mapped;
  assign rsp.map_accepted = res_map_accepted;

endmodule

// ===== rtl/priority_region_memory_map.sv =====
// A result is offered once its accepted command beat has passed the queue and then the
// result register, when the queue and result slot are free.
// Throughput: one command per cycle while results are taken; the front searches all
// regions combinationally and the back makes one backing store access per cycle.
// Reset clears the region count, default_fill and the queue; region table and
// backing store hold no reset value and are valid once written.
module priority_region_memory_map import prm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  prm_in_if.sink     req,
  prm_out_if.source  rsp
);

  logic push;
  op_t  push_op;
  logic queue_full;
  logic head_valid;
  op_t  head;
  logic pop;

  prm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req        (req),
    .queue_full (queue_full),
    .push       (push),
    .push_op    (push_op)
  );

  prm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  prm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .rsp        (rsp)
  );

endmodule

// ===== rtl/prm_checker.sv =====
// Port-level checks of the result channel, bound to the top level.
`include "priority_region_memory_map_assert.svh"

module prm_checker (
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_read_data,
  input logic       rsp_mapped,
  input logic       rsp_map_accepted
);

  `PRM_ASSERT_NEXT(a_valid_hold, rsp_valid && !rsp_ready, rsp_valid, "result beat dropped")
  `PRM_ASSERT_NEXT(a_data_hold, rsp_valid && !rsp_ready, $stable(rsp_read_data), "data moved")
  `PRM_ASSERT_NOW(a_excl, rsp_valid, !(rsp_mapped && rsp_map_accepted), "mapped and accepted")
  `PRM_ASSERT_NOW(a_map_zero, rsp_valid && rsp_map_accepted, rsp_read_data == 8'd0, "map data")

endmodule

bind priority_region_memory_map prm_checker u_prm_checker (
  .clk              (clk),
  .rst              (rst),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_read_data    (rsp.read_data),
  .rsp_mapped       (rsp.mapped),
  .rsp_map_accepted (rsp.map_accepted)
);
